FILE: design/shunting_yard_infix_to_rpn_defines.svh
// Assertion macros shared by the checker of the infix-to-RPN converter.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef SHUNTING_YARD_INFIX_TO_RPN_DEFINES_SVH
`define SHUNTING_YARD_INFIX_TO_RPN_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define SYRPN_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define SYRPN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/syrpn_pkg.sv
// Shared types, codes and character helpers of the infix-to-RPN converter.
// No dependencies; used by every other file of the block but the macro header.
`timescale 1ns / 1ps
`default_nettype none

package syrpn_pkg;

	localparam int STACK_DEPTH_DEF = 16;

	// Result kinds.
	localparam logic [2:0] K_NUM_CONT  = 3'd0;
	localparam logic [2:0] K_NUM_START = 3'd1;
	localparam logic [2:0] K_VAR       = 3'd2;
	localparam logic [2:0] K_OP        = 3'd3;
	localparam logic [2:0] K_DONE      = 3'd4;
	localparam logic [2:0] K_ERR       = 3'd5;

	// Error codes.
	localparam logic [2:0] E_NONE  = 3'd0;
	localparam logic [2:0] E_CHAR  = 3'd1;
	localparam logic [2:0] E_CLOSE = 3'd2;
	localparam logic [2:0] E_OPEN  = 3'd3;
	localparam logic [2:0] E_OVF   = 3'd4;

	// Operator codes as held on the stack.
	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_SUB  = 3'd1;
	localparam logic [2:0] OP_MUL  = 3'd2;
	localparam logic [2:0] OP_DIV  = 3'd3;
	localparam logic [2:0] OP_POW  = 3'd4;
	localparam logic [2:0] OP_OPEN = 3'd5;

	// Characters.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_S  = 8'h53;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_LOW_S = 8'h73;

	// Command from the sequencer to the result buffer.
	typedef struct packed {
		logic       emit;
		logic       fin;
		logic [2:0] kind;
		logic [7:0] chr;
		logic [2:0] err;
	} buf_cmd_t;

	function automatic buf_cmd_t mk_emit(input logic [2:0] kind, input logic [7:0] chr,
			input logic [2:0] err);
		buf_cmd_t r;
		r.emit = 1'b1;
		r.fin  = 1'b0;
		r.kind = kind;
		r.chr  = chr;
		r.err  = err;
		return r;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_num_char(input logic [7:0] c);
		return is_digit(c) || (c == CH_DOT);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_binop(input logic [7:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
			(c == CH_SLASH) || (c == CH_CARET);
	endfunction

	function automatic logic [2:0] binop_code(input logic [7:0] c);
		logic [2:0] r;
		unique case (c)
			CH_PLUS:  r = OP_ADD;
			CH_MINUS: r = OP_SUB;
			CH_STAR:  r = OP_MUL;
			CH_SLASH: r = OP_DIV;
			default:  r = OP_POW;
		endcase
		return r;
	endfunction

	// Codes six and seven never get stored; they fold back as modulo six would.
	function automatic logic [7:0] op_char(input logic [2:0] code);
		logic [7:0] r;
		unique case (code)
			OP_ADD:  r = CH_PLUS;
			OP_SUB:  r = CH_MINUS;
			OP_MUL:  r = CH_STAR;
			OP_DIV:  r = CH_SLASH;
			OP_POW:  r = CH_CARET;
			OP_OPEN: r = CH_OPEN;
			3'd6:    r = CH_PLUS;
			default: r = CH_MINUS;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] op_prec(input logic [2:0] code);
		logic [2:0] r;
		unique case (code)
			OP_MUL, OP_DIV: r = 3'd3;
			OP_POW:         r = 3'd4;
			OP_OPEN:        r = 3'd0;
			default:        r = 3'd2;
		endcase
		return r;
	endfunction

	function automatic logic is_open(input logic [2:0] code);
		return code == OP_OPEN;
	endfunction

endpackage

`default_nettype wire

FILE: design/shunting_yard_infix_to_rpn.sv
// Streaming infix-to-RPN converter: character sequencer around the operator stack.
// Depends on syrpn_pkg, syrpn_stack and syrpn_outbuf.
//
// One character beat goes in, and the tokens it completes come out in reverse
// Polish order, one result beat each, the last of them flagged by run_last.
// A character that touches no stack entry is accepted, decoded and emitted, and
// then the held last result is released. An operator pops each stacked operator
// of higher or, unless it is '^', equal precedence (read the stack top from the
// synchronous memory, then compare and emit), reads and compares the top that
// stays unless the stack is empty, and is then pushed. A '(' is pushed, after an
// implied '*' when one goes in first. A ')' pops each operator down to the
// bracket and removes that too. The first digit of a signed number first emits
// the held '-', and a held '-' that turns out to be binary is handled as that
// operator before its character. The end-of-expression beat flushes every
// stacked operator. Back-pressure on the result side stretches any of these. The
// stack memory needs no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module shunting_yard_infix_to_rpn #(
	parameter int STACK_DEPTH = syrpn_pkg::STACK_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] char_code,
	input  wire logic       end_of_expr,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic      [2:0] token_kind,
	output logic      [7:0] token_char,
	output logic      [2:0] error_code,
	output logic            run_last
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_MNUM,
		ST_TOKEN,
		ST_OP_RD,
		ST_OP_CHK,
		ST_OP_PUSH,
		ST_PAR_MUL,
		ST_PAR_OPEN,
		ST_CL_RD,
		ST_CL_CHK,
		ST_FL_RD,
		ST_FL_CHK,
		ST_FINISH
	} state_t;

	state_t          st_q, st_d, after_st;
	logic [CW-1:0]   cnt_q, cnt_d, cnt_m1;
	logic            prev_op_q, prev_op_d;
	logic            in_num_q, in_num_d;
	logic            dec_q, dec_d;
	logic            minus_q, minus_d;
	logic            err_q, err_d;
	logic            last_q, last_d;
	logic            cont_tok_q, cont_tok_d;
	logic [7:0]      chr_q, chr_d;
	logic [2:0]      op_q, op_d;

	syrpn_pkg::buf_cmd_t cmd;
	logic                buf_ok;
	logic                tok_go;
	logic                full;
	logic                mem_we, mem_re;
	logic [2:0]          mem_wdata, top;
	logic [2:0]          top_prec, new_prec;
	logic                pop_op;

	assign cnt_m1   = cnt_q - CW'(1);
	assign full     = cnt_q >= CW'(STACK_DEPTH);
	assign top_prec = syrpn_pkg::op_prec(top);
	assign new_prec = syrpn_pkg::op_prec(op_q);
	// '^' is right-associative: an equal precedence on top stays put.
	assign pop_op   = (top_prec != 3'd0) &&
		((op_q == syrpn_pkg::OP_POW) ? (new_prec < top_prec) : (new_prec <= top_prec));
	assign in_ready = (st_q == ST_IDLE);

	syrpn_stack #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_stack (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (cnt_m1[AW-1:0]),
		.rdata (top)
	);

	syrpn_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.buf_ok     (buf_ok),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.token_kind (token_kind),
		.token_char (token_char),
		.error_code (error_code),
		.run_last   (run_last)
	);

	// Emitting arms only move on when the buffer takes the result; a stall can still
	// clear the number flags or set prev_op, which is harmless to repeat.
	always_comb begin
		st_d       = st_q;
		cnt_d      = cnt_q;
		prev_op_d  = prev_op_q;
		in_num_d   = in_num_q;
		dec_d      = dec_q;
		minus_d    = minus_q;
		err_d      = err_q;
		last_d     = last_q;
		cont_tok_d = cont_tok_q;
		chr_d      = chr_q;
		op_d       = op_q;
		cmd        = '0;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_wdata  = op_q;
		tok_go     = 1'b0;
		after_st   = last_q ? ST_FL_RD : ST_FINISH;

		unique case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					chr_d  = char_code;
					last_d = end_of_expr;
					st_d   = ST_START;
				end
			end
			ST_START: begin
				priority if (err_q) begin
					if (last_q) begin
						cmd = syrpn_pkg::mk_emit(syrpn_pkg::K_ERR, syrpn_pkg::CH_NUL,
							syrpn_pkg::E_NONE);
						if (buf_ok) begin
							st_d = ST_FINISH;
						end
					end else begin
						st_d = ST_FINISH;
					end
				end else if (minus_q) begin
					if (syrpn_pkg::is_num_char(chr_q)) begin
						cmd = syrpn_pkg::mk_emit(syrpn_pkg::K_NUM_START, syrpn_pkg::CH_MINUS,
							syrpn_pkg::E_NONE);
						if (buf_ok) begin
							minus_d   = 1'b0;
							in_num_d  = 1'b1;
							dec_d     = (chr_q == syrpn_pkg::CH_DOT);
							prev_op_d = 1'b0;
							st_d      = ST_MNUM;
						end
					end else begin
						// The held '-' was binary after all; the character follows it.
						minus_d    = 1'b0;
						op_d       = syrpn_pkg::OP_SUB;
						cont_tok_d = 1'b1;
						st_d       = ST_OP_RD;
					end
				end else begin
					tok_go = 1'b1;
				end
			end
			ST_MNUM: begin
				cmd = syrpn_pkg::mk_emit(syrpn_pkg::K_NUM_CONT, chr_q, syrpn_pkg::E_NONE);
				if (buf_ok) begin
					st_d = after_st;
				end
			end
			ST_TOKEN: begin
				tok_go = 1'b1;
			end
			ST_OP_RD: begin
				if (cnt_q == '0) begin
					st_d = ST_OP_PUSH;
				end else begin
					mem_re = 1'b1;
					st_d   = ST_OP_CHK;
				end
			end
			ST_OP_CHK: begin
				if (pop_op) begin
					cmd = syrpn_pkg::mk_emit(syrpn_pkg::K_OP, syrpn_pkg::op_char(top),
						syrpn_pkg::E_NONE);
					if (buf_ok) begin
						cnt_d = cnt_m1;
						st_d  = ST_OP_RD;
					end
				end else begin
					st_d = ST_OP_PUSH;
				end
			end
			ST_OP_PUSH: begin
				prev_op_d = 1'b1;
				if (full) begin
					cmd = syrpn_pkg::mk_emit(syrpn_pkg::K_ERR, syrpn_pkg::CH_NUL,
						syrpn_pkg::E_OVF);
					if (buf_ok) begin
						err_d      = 1'b1;
						cont_tok_d = 1'b0;
						st_d       = ST_FINISH;
					end
				end else begin
					mem_we     = 1'b1;
					cnt_d      = cnt_q + CW'(1);
					cont_tok_d = 1'b0;
					st_d       = cont_tok_q ? ST_TOKEN : after_st;
				end
			end
			ST_PAR_MUL: begin
				mem_wdata = syrpn_pkg::OP_MUL;
				if (full) begin
					cmd = syrpn_pkg::mk_emit(syrpn_pkg::K_ERR, syrpn_pkg::CH_NUL,
						syrpn_pkg::E_OVF);
					if (buf_ok) begin
						err_d = 1'b1;
						st_d  = ST_FINISH;
					end
				end else begin
					mem_we = 1'b1;
					cnt_d  = cnt_q + CW'(1);
					st_d   = ST_PAR_OPEN;
				end
			end
			ST_PAR_OPEN: begin
				mem_wdata = syrpn_pkg::OP_OPEN;
				if (full) begin
					cmd = syrpn_pkg::mk_emit(syrpn_pkg::K_ERR, syrpn_pkg::CH_NUL,
						syrpn_pkg::E_OVF);
					if (buf_ok) begin
						err_d = 1'b1;
						st_d  = ST_FINISH;
					end
				end else begin
					mem_we    = 1'b1;
					cnt_d     = cnt_q + CW'(1);
					prev_op_d = 1'b1;
					st_d      = after_st;
				end
			end
			ST_CL_RD: begin
				if (cnt_q == '0) begin
					cmd = syrpn_pkg::mk_emit(syrpn_pkg::K_ERR, syrpn_pkg::CH_NUL,
						syrpn_pkg::E_CLOSE);
					if (buf_ok) begin
						err_d = 1'b1;
						st_d  = ST_FINISH;
					end
				end else begin
					mem_re = 1'b1;
					st_d   = ST_CL_CHK;
				end
			end
			ST_CL_CHK: begin
				if (syrpn_pkg::is_open(top)) begin
					cnt_d     = cnt_m1;
					prev_op_d = 1'b0;
					st_d      = after_st;
				end else begin
					cmd = syrpn_pkg::mk_emit(syrpn_pkg::K_OP, syrpn_pkg::op_char(top),
						syrpn_pkg::E_NONE);
					if (buf_ok) begin
						cnt_d = cnt_m1;
						st_d  = ST_CL_RD;
					end
				end
			end
			ST_FL_RD: begin
				if (cnt_q == '0) begin
					cmd = syrpn_pkg::mk_emit(syrpn_pkg::K_DONE, syrpn_pkg::CH_NUL,
						syrpn_pkg::E_NONE);
					if (buf_ok) begin
						st_d = ST_FINISH;
					end
				end else begin
					mem_re = 1'b1;
					st_d   = ST_FL_CHK;
				end
			end
			ST_FL_CHK: begin
				if (syrpn_pkg::op_char(top) == syrpn_pkg::CH_OPEN) begin
					cmd = syrpn_pkg::mk_emit(syrpn_pkg::K_ERR, syrpn_pkg::CH_NUL,
						syrpn_pkg::E_OPEN);
					if (buf_ok) begin
						err_d = 1'b1;
						st_d  = ST_FINISH;
					end
				end else begin
					cmd = syrpn_pkg::mk_emit(syrpn_pkg::K_OP, syrpn_pkg::op_char(top),
						syrpn_pkg::E_NONE);
					if (buf_ok) begin
						cnt_d = cnt_m1;
						st_d  = ST_FL_RD;
					end
				end
			end
			ST_FINISH: begin
				cmd.fin = 1'b1;
				if (buf_ok) begin
					// The end of an expression puts the stack and the parse flags back to their start.
					if (last_q) begin
						cnt_d     = '0;
						prev_op_d = 1'b1;
						in_num_d  = 1'b0;
						dec_d     = 1'b0;
						minus_d   = 1'b0;
						err_d     = 1'b0;
					end
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase

		// Ordinary decoding of the current character.
		if (tok_go) begin
			priority if (in_num_q && syrpn_pkg::is_digit(chr_q)) begin
				cmd = syrpn_pkg::mk_emit(syrpn_pkg::K_NUM_CONT, chr_q, syrpn_pkg::E_NONE);
				if (buf_ok) begin
					st_d = after_st;
				end
			end else if (in_num_q && (chr_q == syrpn_pkg::CH_DOT)) begin
				if (dec_q) begin
					cmd = syrpn_pkg::mk_emit(syrpn_pkg::K_ERR, syrpn_pkg::CH_NUL,
						syrpn_pkg::E_CHAR);
					if (buf_ok) begin
						err_d = 1'b1;
						st_d  = ST_FINISH;
					end
				end else begin
					cmd = syrpn_pkg::mk_emit(syrpn_pkg::K_NUM_CONT, chr_q, syrpn_pkg::E_NONE);
					if (buf_ok) begin
						dec_d = 1'b1;
						st_d  = after_st;
					end
				end
			end else begin
				// Anything else ends a number; repeating this during a stall is harmless.
				in_num_d = 1'b0;
				dec_d    = 1'b0;
				priority if (syrpn_pkg::is_space(chr_q)) begin
					st_d = after_st;
				end else if (syrpn_pkg::is_num_char(chr_q)) begin
					cmd = syrpn_pkg::mk_emit(syrpn_pkg::K_NUM_START, chr_q, syrpn_pkg::E_NONE);
					if (buf_ok) begin
						in_num_d  = 1'b1;
						dec_d     = (chr_q == syrpn_pkg::CH_DOT);
						prev_op_d = 1'b0;
						st_d      = after_st;
					end
				end else if ((chr_q == syrpn_pkg::CH_MINUS) && prev_op_q && !last_q) begin
					// Could be a sign; the next character decides.
					minus_d = 1'b1;
					st_d    = after_st;
				end else if ((chr_q == syrpn_pkg::CH_LOW_S) || (chr_q == syrpn_pkg::CH_UP_S)) begin
					cmd = syrpn_pkg::mk_emit(syrpn_pkg::K_VAR, syrpn_pkg::CH_NUL,
						syrpn_pkg::E_NONE);
					if (buf_ok) begin
						prev_op_d = 1'b0;
						st_d      = after_st;
					end
				end else if (syrpn_pkg::is_binop(chr_q)) begin
					op_d       = syrpn_pkg::binop_code(chr_q);
					cont_tok_d = 1'b0;
					st_d       = ST_OP_RD;
				end else if (chr_q == syrpn_pkg::CH_OPEN) begin
					st_d = prev_op_q ? ST_PAR_OPEN : ST_PAR_MUL;
				end else if (chr_q == syrpn_pkg::CH_CLOSE) begin
					st_d = ST_CL_RD;
				end else begin
					cmd = syrpn_pkg::mk_emit(syrpn_pkg::K_ERR, syrpn_pkg::CH_NUL,
						syrpn_pkg::E_CHAR);
					if (buf_ok) begin
						err_d = 1'b1;
						st_d  = ST_FINISH;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			cnt_q      <= '0;
			prev_op_q  <= 1'b1;
			in_num_q   <= 1'b0;
			dec_q      <= 1'b0;
			minus_q    <= 1'b0;
			err_q      <= 1'b0;
			last_q     <= 1'b0;
			cont_tok_q <= 1'b0;
			chr_q      <= '0;
			op_q       <= '0;
		end else begin
			st_q       <= st_d;
			cnt_q      <= cnt_d;
			prev_op_q  <= prev_op_d;
			in_num_q   <= in_num_d;
			dec_q      <= dec_d;
			minus_q    <= minus_d;
			err_q      <= err_d;
			last_q     <= last_d;
			cont_tok_q <= cont_tok_d;
			chr_q      <= chr_d;
			op_q       <= op_d;
		end
	end

endmodule

`default_nettype wire

FILE: design/syrpn_stack.sv
// Operator stack store: one write port and one registered read port.
// Depends on syrpn_pkg for its default depth; sized by the top level's stack depth.
`timescale 1ns / 1ps
`default_nettype none

module syrpn_stack #(
	parameter int DEPTH = syrpn_pkg::STACK_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [2:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [2:0]    rdata
);

	logic [2:0] mem [DEPTH];

	// Read data only changes on a read, so a stalled compare sees the same top.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: design/syrpn_outbuf.sv
// Result buffer: a holding slot for the newest result plus the output register.
// Depends on syrpn_pkg for the command struct.
`timescale 1ns / 1ps
`default_nettype none

module syrpn_outbuf (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire syrpn_pkg::buf_cmd_t cmd,
	output logic                     buf_ok,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic      [2:0]          token_kind,
	output logic      [7:0]          token_char,
	output logic      [2:0]          error_code,
	output logic                     run_last
);

	// A result waits in the holding slot until the sequencer either produces
	// another one (so it was not the last) or finishes the item (so it was).
	logic       hold_valid_q;
	logic [2:0] hold_kind_q;
	logic [7:0] hold_chr_q;
	logic [2:0] hold_err_q;
	logic       out_valid_q;
	logic       out_free;
	logic       push_out;
	logic       take;

	assign out_free = !out_valid_q || out_ready;
	assign buf_ok   = !hold_valid_q || out_free;
	assign take     = cmd.emit && buf_ok;
	assign push_out = hold_valid_q && out_free && (cmd.emit || cmd.fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				hold_valid_q <= 1'b1;
			end else if (cmd.fin && buf_ok) begin
				hold_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_out) begin
			token_kind <= hold_kind_q;
			token_char <= hold_chr_q;
			error_code <= hold_err_q;
			run_last   <= cmd.fin;
		end
		if (take) begin
			hold_kind_q <= cmd.kind;
			hold_chr_q  <= cmd.chr;
			hold_err_q  <= cmd.err;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: design/syrpn_checker.sv
// Port-level checker of the infix-to-RPN converter, bound to the top level.
// Depends on syrpn_pkg and the macros in shunting_yard_infix_to_rpn_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "shunting_yard_infix_to_rpn_defines.svh"

module syrpn_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] token_kind,
	input wire logic [7:0] token_char,
	input wire logic [2:0] error_code,
	input wire logic       run_last
);

	// A result beat that is not taken stays put.
	`SYRPN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(token_kind) && $stable(token_char) && $stable(error_code) && $stable(run_last), "result beat changed while stalled")

	`SYRPN_ASSERT_NOW(a_err_code_only_on_err, out_valid && (token_kind != syrpn_pkg::K_ERR), error_code == syrpn_pkg::E_NONE, "error code on a non-error beat")

	`SYRPN_ASSERT_NOW(a_char_zero, out_valid && ((token_kind == syrpn_pkg::K_VAR) || (token_kind == syrpn_pkg::K_DONE) || (token_kind == syrpn_pkg::K_ERR)), token_char == syrpn_pkg::CH_NUL, "character on a kind that carries none")

	// The completion beat always closes the run of its character.
	`SYRPN_ASSERT_NOW(a_done_is_last, out_valid && (token_kind == syrpn_pkg::K_DONE), run_last, "completion beat not flagged last")

endmodule

bind shunting_yard_infix_to_rpn syrpn_checker u_syrpn_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.token_kind (token_kind),
	.token_char (token_char),
	.error_code (error_code),
	.run_last   (run_last)
);

`default_nettype wire
